// ===== hdl/srde_pkg.sv =====
`timescale 1ns / 1ps

package srde_pkg;

    localparam int VALUE_BITS  = 32;
    localparam int MAX_RADIX   = 32;
    localparam int ALPHA_CAP   = 32;

    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = $clog2(ALPHA_CAP);
    localparam int STACK_DEPTH = VALUE_BITS;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int STEP_BITS   = 4;
    localparam int STEPS       = VALUE_BITS / STEP_BITS;
    localparam int STEP_W      = $clog2(STEPS);

    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [2:0] REG_RADIX   = 3'd0;
    localparam logic [2:0] REG_ALPHA_A = 3'd1;
    localparam logic [2:0] REG_ALPHA_B = 3'd2;
    localparam logic [2:0] REG_ALPHA_C = 3'd3;
    localparam logic [2:0] REG_ALPHA_D = 3'd4;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd2;
    localparam logic [DATA_W-1:0]  ALPHA_A_RESET = 64'h3130;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef logic [7:0]                 t_char;
    typedef logic [DIGIT_W-1:0]         t_digit;
    typedef logic [ALPHA_CAP-1:0][7:0]  t_alpha;

    typedef struct packed {
        logic load;
        logic chk_inc;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
        logic rd_digit;
    } t_cmd;

    typedef struct packed {
        logic radix_ok;
        logic char_bad;
        logic chk_last;
        logic step_last;
        logic quot_zero;
        logic neg;
        logic out_free;
        logic digit_last;
    } t_sts;

endpackage

// ===== hdl/srde_if.sv =====
`timescale 1ns / 1ps

interface srde_in_if;
    logic                                       valid;
    logic                                       ready;
    logic signed [srde_pkg::VALUE_BITS-1:0]     value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== hdl/signed_radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// After a value is transferred, the alphabet is checked, one character of it a cycle for
// the R = radix characters in use, then the 4-bit-a-cycle divider yields the D digits.
// The characters then go out back to back while o_out.ready does not stall them, with a
// minus sign before the digits of a negative value.
// Reset (i_rst_n, synchronous, active low): idle, no output, radix 2, alphabet "01".

module signed_radix_digit_emitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    srde_in_if.sink                           i_in,
    srde_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [srde_pkg::ADDR_W-1:0]       paddr,
    input  logic [srde_pkg::DATA_W-1:0]       pwdata,
    output logic [srde_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    logic [srde_pkg::RADIX_W-1:0] radix;
    srde_pkg::t_alpha             alpha;
    srde_pkg::t_cmd               cmd;
    srde_pkg::t_sts               sts;
    logic                         in_ready;

    srde_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_radix (radix),
        .o_alpha (alpha)
    );

    srde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    srde_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in.value),
        .i_radix     (radix),
        .i_alpha     (alpha),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.out_char),
        .o_out_last  (o_out.last_char)
    );

    assign i_in.ready = in_ready;

endmodule

// ===== hdl/srde_regs.sv =====
`timescale 1ns / 1ps

module srde_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [srde_pkg::ADDR_W-1:0]        paddr,
    input  logic [srde_pkg::DATA_W-1:0]        pwdata,
    output logic [srde_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    output logic [srde_pkg::RADIX_W-1:0]       o_radix,
    output srde_pkg::t_alpha                   o_alpha
);

    logic [srde_pkg::RADIX_W-1:0] r_radix;
    logic [srde_pkg::DATA_W-1:0]  r_word_a;
    logic [srde_pkg::DATA_W-1:0]  r_word_b;
    logic [srde_pkg::DATA_W-1:0]  r_word_c;
    logic [srde_pkg::DATA_W-1:0]  r_word_d;
    logic [2:0]                   reg_idx;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[srde_pkg::ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= srde_pkg::RADIX_RESET;
            r_word_a <= srde_pkg::ALPHA_A_RESET;
            r_word_b <= '0;
            r_word_c <= '0;
            r_word_d <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                srde_pkg::REG_RADIX:   r_radix  <= pwdata[srde_pkg::RADIX_W-1:0];
                srde_pkg::REG_ALPHA_A: r_word_a <= pwdata;
                srde_pkg::REG_ALPHA_B: r_word_b <= pwdata;
                srde_pkg::REG_ALPHA_C: r_word_c <= pwdata;
                srde_pkg::REG_ALPHA_D: r_word_d <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            srde_pkg::REG_RADIX:   prdata = {{(srde_pkg::DATA_W-srde_pkg::RADIX_W){1'b0}}, r_radix};
            srde_pkg::REG_ALPHA_A: prdata = r_word_a;
            srde_pkg::REG_ALPHA_B: prdata = r_word_b;
            srde_pkg::REG_ALPHA_C: prdata = r_word_c;
            srde_pkg::REG_ALPHA_D: prdata = r_word_d;
            default:               prdata = '0;
        endcase
    end

    assign o_radix = r_radix;
    assign o_alpha = {r_word_d, r_word_c, r_word_b, r_word_a};

endmodule

// ===== hdl/srde_ctrl.sv =====
`timescale 1ns / 1ps

module srde_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  srde_pkg::t_sts   i_sts,
    output logic             o_in_ready,
    output srde_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.radix_ok ? S_CHECK : S_IDLE;
                end
            end
            S_CHECK: begin
                o_cmd.chk_inc = 1'b1;
                if (i_sts.char_bad) begin
                    n_state = S_IDLE;
                end else if (i_sts.chk_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last && i_sts.quot_zero) begin
                    n_state = i_sts.neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.rd_digit = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_sts.digit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ===== hdl/srde_dp.sv =====
`timescale 1ns / 1ps

module srde_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srde_pkg::t_cmd                    i_cmd,
    input  logic [srde_pkg::VALUE_BITS-1:0]   i_value,
    input  logic [srde_pkg::RADIX_W-1:0]      i_radix,
    input  srde_pkg::t_alpha                  i_alpha,
    input  logic                              i_out_ready,
    output srde_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output srde_pkg::t_char                   o_out_char,
    output logic                              o_out_last
);

    logic [srde_pkg::VALUE_BITS-1:0]  r_mag;
    logic                             r_neg;
    srde_pkg::t_digit                 r_rem;
    logic [srde_pkg::STEP_W-1:0]      r_step;
    srde_pkg::t_digit                 r_idx;
    srde_pkg::t_digit                 r_stack [srde_pkg::STACK_DEPTH];
    logic [srde_pkg::DEPTH_W-1:0]     r_depth;
    logic                             r_out_valid;
    srde_pkg::t_char                  r_out_char;
    logic                             r_out_last;

    logic [srde_pkg::VALUE_BITS-1:0]  load_mag;
    logic [srde_pkg::STEP_BITS-1:0]   quot_bits;
    srde_pkg::t_digit                 rem_next;
    logic [srde_pkg::DIGIT_W:0]       trial;
    logic [srde_pkg::VALUE_BITS-1:0]  mag_next;
    srde_pkg::t_digit                 rd_addr;
    srde_pkg::t_char                  rd_char;
    logic                             dup;
    logic                             step_last;
    logic                             out_free;
    logic                             digit_last;

    assign load_mag = i_value[srde_pkg::VALUE_BITS-1]
                    ? (srde_pkg::VALUE_BITS'(0) - i_value) : i_value;

    // restoring division, STEP_BITS quotient bits a cycle
    always_comb begin
        rem_next  = r_rem;
        quot_bits = '0;
        trial     = '0;
        for (int k = 0; k < srde_pkg::STEP_BITS; k++) begin
            trial = {rem_next, r_mag[srde_pkg::VALUE_BITS-1-k]};
            if (trial >= i_radix) begin
                trial = trial - i_radix;
                quot_bits[srde_pkg::STEP_BITS-1-k] = 1'b1;
            end
            rem_next = trial[srde_pkg::DIGIT_W-1:0];
        end
    end

    assign mag_next  = {r_mag[srde_pkg::VALUE_BITS-srde_pkg::STEP_BITS-1:0], quot_bits};
    assign step_last = (r_step == srde_pkg::STEP_W'(srde_pkg::STEPS - 1));

    assign rd_addr = i_cmd.rd_digit ? r_stack[0] : r_idx;
    assign rd_char = i_alpha[rd_addr];

    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < srde_pkg::ALPHA_CAP; j++) begin
            if ((srde_pkg::DIGIT_W'(j) > r_idx)
                && ((srde_pkg::DIGIT_W+1)'(j) < i_radix)
                && (i_alpha[j] == rd_char)) begin
                dup = 1'b1;
            end
        end
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign digit_last = (r_depth == srde_pkg::DEPTH_W'(1));

    always_comb begin
        o_sts            = '0;
        o_sts.radix_ok   = (i_radix >= srde_pkg::RADIX_W'(2))
                        && (i_radix <= srde_pkg::RADIX_W'(srde_pkg::MAX_RADIX))
                        && (i_radix <= srde_pkg::RADIX_W'(srde_pkg::ALPHA_CAP));
        o_sts.char_bad   = (rd_char == srde_pkg::CHAR_PLUS)
                        || (rd_char == srde_pkg::CHAR_MINUS)
                        || (rd_char < srde_pkg::CHAR_SPACE)
                        || (rd_char > srde_pkg::CHAR_TILDE)
                        || dup;
        o_sts.chk_last   = ({1'b0, r_idx} == (i_radix - srde_pkg::RADIX_W'(1)));
        o_sts.step_last  = step_last;
        o_sts.quot_zero  = (mag_next == '0);
        o_sts.neg        = r_neg;
        o_sts.out_free   = out_free;
        o_sts.digit_last = digit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step  <= '0;
                r_depth <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + srde_pkg::STEP_W'(1);
                if (step_last) begin
                    r_depth <= r_depth + srde_pkg::DEPTH_W'(1);
                end
            end else if (i_cmd.emit_digit) begin
                r_depth <= r_depth - srde_pkg::DEPTH_W'(1);
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= load_mag;
            r_neg <= i_value[srde_pkg::VALUE_BITS-1];
            r_rem <= '0;
            r_idx <= '0;
        end
        if (i_cmd.chk_inc) begin
            r_idx <= r_idx + srde_pkg::DIGIT_W'(1);
        end
        if (i_cmd.div_step) begin
            r_mag <= mag_next;
            r_rem <= step_last ? '0 : rem_next;
            if (step_last) begin
                r_stack[0] <= rem_next;
                for (int k = 1; k < srde_pkg::STACK_DEPTH; k++) begin
                    r_stack[k] <= r_stack[k-1];
                end
            end
        end
        if (i_cmd.emit_digit) begin
            for (int k = 0; k < srde_pkg::STACK_DEPTH - 1; k++) begin
                r_stack[k] <= r_stack[k+1];
            end
        end
        if (i_cmd.emit_sign) begin
            r_out_char <= srde_pkg::CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= rd_char;
            r_out_last <= digit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= srde_pkg::DEPTH_W'(srde_pkg::STACK_DEPTH))
        else $error("digit stack overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (r_depth != '0))
        else $error("digit popped from empty stack");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ({1'b0, r_rem} < i_radix))
        else $error("remainder not below radix");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_digit && digit_last) |=> (r_out_valid && r_out_last))
        else $error("final digit not marked last");

endmodule
